FILE: hdl/tricubic_spline_lookup_core_assert.svh
// Assertion macros for the tricubic spline lookup core.
// Used by the controller and the top level; no other dependencies.
`ifndef TRICUBIC_SPLINE_LOOKUP_CORE_ASSERT_SVH
`define TRICUBIC_SPLINE_LOOKUP_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TSL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TSL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TSL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/tsl_pkg.sv
// Shared types, constants and helper functions for the tricubic spline lookup core.
// No dependencies.
`default_nettype none
package tsl_pkg;
   localparam int DIM_X = 8;
   localparam int DIM_Y = 8;
   localparam int DIM_Z = 16;
   localparam int COEF_TERMS = 64;
   localparam int COEF_AW = 16;
   localparam int GRID_AW = 10;

   localparam logic [1:0] CMD_COEF = 2'd0;
   localparam logic [1:0] CMD_GRID = 2'd1;
   localparam logic [1:0] CMD_EVAL = 2'd2;

   localparam logic [2:0] REG_TOL     = 3'd0;
   localparam logic [2:0] REG_LO_IJ   = 3'd1;
   localparam logic [2:0] REG_HI_IJ   = 3'd2;
   localparam logic [2:0] REG_LO_JI   = 3'd3;
   localparam logic [2:0] REG_HI_JI   = 3'd4;
   localparam logic [2:0] REG_LO_CONJ = 3'd5;
   localparam logic [2:0] REG_HI_CONJ = 3'd6;

   localparam logic signed [47:0] PART_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] PART_MIN = {1'b1, {47{1'b0}}};

   // axis select for the Horner multiplier
   typedef enum logic [1:0] {AX_Z = 2'd0, AX_Y = 2'd1, AX_X = 2'd2} axis_type;

   typedef struct packed {
      logic     load_grid;  // latch grid address, start grid read
      logic     grid_done;  // present grid result
      logic     coef_read;  // issue coefficient read for term_idx
      logic     mul;        // multiply accumulator by axis coordinate
      logic     add;        // add operand to product, clamp
      logic     init;       // load accumulator from operand
      logic     push;       // store accumulator into level buffer
      axis_type axis;
      logic [5:0] term_idx;
      logic [1:0] src;      // 0 coefficient, 1 z level, 2 y level
      logic [1:0] pidx;     // buffer index for operand
      logic [1:0] widx;     // buffer index for push
      logic     finish;     // present polynomial result
   } ctl_cmd_type;

   localparam logic [1:0] SRC_COEF = 2'd0;
   localparam logic [1:0] SRC_ZLV  = 2'd1;
   localparam logic [1:0] SRC_YLV  = 2'd2;

   function automatic logic [15:0] clamp_coord(input logic [15:0] n, input logic [3:0] lo,
                                               input logic [3:0] hi);
      logic [15:0] v;
      v = n;
      if (v < {lo, 12'd0}) v = {lo, 12'd0};
      if (v > {hi, 12'd0}) v = {hi, 12'd0};
      return v;
   endfunction

   function automatic logic [3:0] pick_cell(input logic [15:0] v, input logic [3:0] hi);
      logic [3:0] f;
      f = v[15:12];
      if (hi == 4'd0) return 4'd0;
      return (f < hi) ? f : hi - 4'd1;
   endfunction
endpackage
`default_nettype wire

FILE: hdl/tsl_ctrl.sv
// Sequencer for the tricubic spline lookup: walks the Horner schedule per evaluate, or the grid read.
// Depends on tsl_pkg and the assertion macro header.
`default_nettype none
`include "tricubic_spline_lookup_core_assert.svh"
module tsl_ctrl import tsl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go_poly,
   input  wire logic        go_grid,
   output ctl_cmd_type      cmd,
   output logic             busy
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_GRID  = 7'b0000010,
      S_GOUT  = 7'b0000100,
      S_READ  = 7'b0001000,
      S_INIT  = 7'b0010000,
      S_MUL   = 7'b0100000,
      S_ADD   = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   // k,j,i: Horner steps; lvl 0=z 1=y 2=x
   logic [1:0] k_ff, k_in, j_ff, j_in, i_ff, i_in, lvl_ff, lvl_in;

   logic [5:0] term;
   always_comb begin
      cmd = '0;
      cmd.axis = AX_Z;
      cmd.src = SRC_COEF;
      state_in = state_ff;
      k_in = k_ff; j_in = j_ff; i_in = i_ff; lvl_in = lvl_ff;
      // operand index for this step: coefficient term or buffer slot
      term = {i_ff, j_ff, k_ff};
      case (lvl_ff)
         2'd0: begin cmd.axis = AX_Z; cmd.src = SRC_COEF; end
         2'd1: begin cmd.axis = AX_Y; cmd.src = SRC_ZLV; end
         default: begin cmd.axis = AX_X; cmd.src = SRC_YLV; end
      endcase
      cmd.term_idx = term;
      cmd.pidx = k_ff;
      case (state_ff)
         S_IDLE: begin
            if (go_grid) begin
               cmd.load_grid = 1'b1;
               state_in = S_GRID;
            end else if (go_poly) begin
               k_in = 2'd3; j_in = 2'd3; i_in = 2'd3; lvl_in = 2'd0;
               state_in = S_READ;
            end
         end
         S_GRID: state_in = S_GOUT;
         S_GOUT: begin
            cmd.grid_done = 1'b1;
            state_in = S_IDLE;
         end
         S_READ: begin
            cmd.coef_read = (lvl_ff == 2'd0);
            state_in = (k_ff == 2'd3) ? S_INIT : S_ADD;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            k_in = k_ff - 2'd1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_READ;
         end
         S_ADD: begin
            cmd.add = 1'b1;
            if (k_ff != 2'd0) begin
               k_in = k_ff - 2'd1;
               state_in = S_MUL;
            end else begin
               k_in = 2'd3;
               // level finished: push result, or present it at the last level
               cmd.push = 1'b1;
               case (lvl_ff)
                  2'd0: begin
                     cmd.widx = j_ff;
                     if (j_ff != 2'd0) begin
                        j_in = j_ff - 2'd1;
                     end else begin
                        lvl_in = 2'd1;
                     end
                     state_in = S_READ;
                  end
                  2'd1: begin
                     cmd.widx = i_ff;
                     if (i_ff != 2'd0) begin
                        i_in = i_ff - 2'd1;
                        j_in = 2'd3;
                        lvl_in = 2'd0;
                     end else begin
                        lvl_in = 2'd2;
                     end
                     state_in = S_READ;
                  end
                  default: begin
                     cmd.push = 1'b0;
                     cmd.finish = 1'b1;
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_ADD && k_ff != 2'd0) cmd.mul = 1'b0;
   end

   // INIT and every non-final ADD hand over to MUL before the next operand read.
   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff <= '0; j_ff <= '0; i_ff <= '0; lvl_ff <= '0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in; j_ff <= j_in; i_ff <= i_in; lvl_ff <= lvl_in;
      end
   end

   `TSL_ASSERT_IMPL(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `TSL_ASSERT_NEXT(a_grid_out, clock, reset, state_ff == S_GRID, state_ff == S_GOUT)
   `TSL_ASSERT_IMPL(a_idle_start, clock, reset, (go_poly || go_grid) && busy, 1'b0)
endmodule
`default_nettype wire

FILE: hdl/tsl_datapath.sv
// Datapath: coefficient and grid memories, Horner multiply-add, level buffers.
// Depends on tsl_pkg; driven by tsl_ctrl commands.
`default_nettype none
module tsl_datapath import tsl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               load_coef,
   input  wire logic               load_grid_wr,
   input  wire logic [15:0]        wr_addr,
   input  wire logic signed [31:0] wr_value,
   input  wire logic               latch,
   input  wire logic [15:0]        x_in,
   input  wire logic [15:0]        y_in,
   input  wire logic [15:0]        z_in,
   input  wire logic [15:0]        coef_base_in,
   input  wire logic [9:0]         grid_addr_in,
   input  ctl_cmd_type             cmd,
   output logic signed [31:0]      value,
   output logic                    sat_out
);
   logic [31:0] coef_mem [2**COEF_AW];
   logic [31:0] grid_mem [2**GRID_AW];
   logic [31:0] coef_rd_ff, grid_rd_ff;
   logic [15:0] x_ff, y_ff, z_ff, base_ff;
   logic [9:0]  gaddr_ff;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [50:0] rp_ff, rp_in;
   logic signed [47:0] zlv_ff [4];
   logic signed [47:0] ylv_ff [4];
   logic sat_ff, sat_in;
   logic [15:0] coord;
   logic signed [47:0] operand;
   logic signed [64:0] prod;
   logic signed [64:0] rnd;
   logic signed [51:0] sum;

   always_ff @(posedge clock) begin
      if (load_coef) coef_mem[wr_addr] <= wr_value;
      if (load_grid_wr) grid_mem[wr_addr[GRID_AW-1:0]] <= wr_value;
      if (cmd.coef_read) coef_rd_ff <= coef_mem[base_ff + {10'd0, cmd.term_idx}];
      grid_rd_ff <= grid_mem[gaddr_ff];
   end

   always_comb begin
      case (cmd.axis)
         AX_Z: coord = z_ff;
         AX_Y: coord = y_ff;
         default: coord = x_ff;
      endcase
      case (cmd.src)
         SRC_COEF: operand = 48'(signed'(coef_rd_ff));
         SRC_ZLV:  operand = zlv_ff[cmd.pidx];
         default:  operand = ylv_ff[cmd.pidx];
      endcase
      prod = 65'(acc_ff) * $signed({1'b0, coord});
      rnd = (prod + 65'sd2048) >>> 12;
      // rp holds the rounded product after mul
      sum = 52'(rp_ff) + 52'(operand);
      acc_in = acc_ff;
      rp_in = rp_ff;
      sat_in = sat_ff;
      if (cmd.init) acc_in = operand;
      if (cmd.add) begin
         if (sum > 52'(PART_MAX)) begin acc_in = PART_MAX; sat_in = 1'b1; end
         else if (sum < 52'(PART_MIN)) begin acc_in = PART_MIN; sat_in = 1'b1; end
         else acc_in = sum[47:0];
      end
      if (cmd.mul) rp_in = rnd[50:0];
   end

   always_ff @(posedge clock) begin
      if (latch) begin
         x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
         base_ff <= coef_base_in; gaddr_ff <= grid_addr_in;
         sat_ff <= 1'b0;
      end else begin
         sat_ff <= sat_in;
      end
      acc_ff <= acc_in;
      rp_ff <= rp_in;
      if (cmd.push) begin
         if (cmd.src == SRC_COEF) zlv_ff[cmd.widx] <= acc_in;
         else ylv_ff[cmd.widx] <= acc_in;
      end
   end

   logic signed [31:0] fin;
   logic fsat;
   always_comb begin
      fsat = sat_in;
      if (acc_in > 48'sh7FFFFFFF) begin fin = 32'h7FFFFFFF; fsat = 1'b1; end
      else if (acc_in < -48'sh80000000) begin fin = 32'h80000000; fsat = 1'b1; end
      else fin = acc_in[31:0];
      value = cmd.grid_done ? signed'(grid_rd_ff) : fin;
      sat_out = cmd.grid_done ? 1'b0 : fsat;
   end
endmodule
`default_nettype wire

FILE: hdl/tricubic_spline_lookup_core.sv
// Tricubic spline lookup core. Load beats may run back to back while the core is idle.
// A grid answer is strobed from state S_GOUT, after S_GRID and a registered grid read;
// a polynomial evaluate runs 21 Horner chains of 3 multiply-add steps on the single
// shared multiplier. No new request is taken until the answer is strobed. Synchronous
// active-high reset returns control and configuration registers to their defaults;
// rsp_valid lasts one cycle, cannot be stalled.
`default_nettype none
`include "tricubic_spline_lookup_core_assert.svh"
module tricubic_spline_lookup_core import tsl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [15:0]        req_load_addr,
   input  wire logic signed [31:0] req_load_value,
   input  wire logic [15:0]        req_n_ij,
   input  wire logic [15:0]        req_n_ji,
   input  wire logic [15:0]        req_n_conj,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [11:0]        csr_wdata,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_spline_value,
   output logic                    rsp_from_grid,
   output logic                    rsp_saturated
);
   logic [11:0] tol_ff;
   logic [2:0]  lo_ij_ff, hi_ij_ff, lo_ji_ff, hi_ji_ff;
   logic [3:0]  lo_conj_ff, hi_conj_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= 12'd1; lo_ij_ff <= 3'd1; hi_ij_ff <= 3'd4;
         lo_ji_ff <= 3'd1; hi_ji_ff <= 3'd4; lo_conj_ff <= 4'd1; hi_conj_ff <= 4'd9;
      end else if (csr_we) begin
         case (csr_index)
            REG_TOL:     tol_ff <= csr_wdata;
            REG_LO_IJ:   lo_ij_ff <= csr_wdata[2:0];
            REG_HI_IJ:   hi_ij_ff <= csr_wdata[2:0];
            REG_LO_JI:   lo_ji_ff <= csr_wdata[2:0];
            REG_HI_JI:   hi_ji_ff <= csr_wdata[2:0];
            REG_LO_CONJ: lo_conj_ff <= csr_wdata[3:0];
            REG_HI_CONJ: hi_conj_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   logic accept;
   logic [15:0] x, y, z;
   logic [3:0] cx, cy, cz;
   logic is_grid;
   logic [15:0] base;
   logic [9:0] gaddr;
   ctl_cmd_type cmd;

   assign accept = start && !busy;
   always_comb begin
      x = clamp_coord(req_n_ij, {1'b0, lo_ij_ff}, {1'b0, hi_ij_ff});
      y = clamp_coord(req_n_ji, {1'b0, lo_ji_ff}, {1'b0, hi_ji_ff});
      z = clamp_coord(req_n_conj, lo_conj_ff, hi_conj_ff);
      is_grid = (x[11:0] < tol_ff) && (y[11:0] < tol_ff) && (z[11:0] < tol_ff);
      gaddr = {x[14:12], y[14:12], z[15:12]};
      cx = pick_cell(x, {1'b0, hi_ij_ff});
      cy = pick_cell(y, {1'b0, hi_ji_ff});
      cz = pick_cell(z, hi_conj_ff);
      base = {cx[2:0], cy[2:0], cz[3:0], 6'd0};
   end

   tsl_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .go_poly(accept && req_cmd == CMD_EVAL && !is_grid),
      .go_grid(accept && req_cmd == CMD_EVAL && is_grid),
      .cmd(cmd), .busy(busy)
   );

   tsl_datapath u_dp (
      .clock(clock),
      .load_coef(accept && req_cmd == CMD_COEF),
      .load_grid_wr(accept && req_cmd == CMD_GRID),
      .wr_addr(req_load_addr), .wr_value(req_load_value),
      .latch(accept && req_cmd == CMD_EVAL),
      .x_in(x), .y_in(y), .z_in(z), .coef_base_in(base), .grid_addr_in(gaddr),
      .cmd(cmd), .value(rsp_spline_value), .sat_out(rsp_saturated)
   );

   assign rsp_valid = cmd.finish || cmd.grid_done;
   assign rsp_from_grid = cmd.grid_done;

   `TSL_ASSERT_IMPL(a_one_src, clock, reset, rsp_valid, !(cmd.finish && cmd.grid_done))
   `TSL_ASSERT_IMPL(a_busy_rsp, clock, reset, rsp_valid, busy)
   `TSL_ASSERT_NEXT(a_done_idle, clock, reset, rsp_valid, !busy)
endmodule
`default_nettype wire
